/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/jaos_pkg.sv */
// Shared types and constants for the JSON array object splitter
package jaos_pkg;

    localparam int DEPTH_BITS = 8;
    localparam int COUNT_BITS = 16;
    localparam int LIMIT_BITS = 16;
    localparam int CMP_W      = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1023);

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_OBJECT,
        MODE_DONE
    } mode_t;

    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       object_end;
        logic       truncated;
        logic       incomplete;
        logic       array_end;
    } obj_result_t;

    // One parse step: whether a result came out, and its fields
    typedef struct packed {
        logic        has_result;
        obj_result_t result;
    } step_out_t;

endpackage

/* hdl/jaos_ifs.sv */
// Channel interfaces: text input, object output, limit configuration
interface jaos_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jaos_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       object_end;
    logic       truncated;
    logic       incomplete;
    logic       array_end;

    modport source (output valid, output data_byte, output byte_valid, output object_end,
                    output truncated, output incomplete, output array_end, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input object_end,
                    input truncated, input incomplete, input array_end, output ready);
endinterface

interface jaos_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] object_byte_limit;

    modport source (output valid, output object_byte_limit, input ready);
    modport sink   (input valid, input object_byte_limit, output ready);
endinterface

/* hdl/jaos_core.sv */
// Parse state and single-step update for one text byte
module jaos_core
    import jaos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  limit_t     limit,
    output step_out_t  step_out
);

    localparam depth_t DEPTH_MAX = '1;
    localparam count_t COUNT_MAX = '1;

    mode_t  mode_reg, mode_next;
    logic   str_reg, str_next;
    logic   esc_reg, esc_next;
    depth_t depth_reg, depth_next;
    count_t count_reg, count_next;
    logic   drop_reg, drop_next;

    logic   obj_go;
    logic   closed;
    logic   passed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            depth_reg <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            depth_reg <= depth_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        str_next   = str_reg;
        esc_next   = esc_reg;
        depth_next = depth_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        obj_go     = 1'b0;
        closed     = 1'b0;
        passed     = 1'b0;
        step_out   = '0;

        case (mode_reg)
            MODE_DONE:
            begin
                if (end_of_text)
                    mode_next = MODE_BETWEEN;
            end
            MODE_BETWEEN:
            begin
                // object state is already clear here
                if (text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_LBRACK, CH_COMMA})
                begin
                    mode_next = MODE_BETWEEN;
                end
                else if (text_byte != CH_LBRACE)
                begin
                    step_out.has_result       = 1'b1;
                    step_out.result.array_end = 1'b1;
                    mode_next = end_of_text ? MODE_BETWEEN : MODE_DONE;
                end
                else
                begin
                    obj_go = 1'b1;
                end
            end
            MODE_OBJECT:
            begin
                obj_go = 1'b1;
            end
            default:
            begin
                mode_next = MODE_BETWEEN;
            end
        endcase

        if (obj_go)
        begin
            mode_next = MODE_OBJECT;
            if (esc_reg)
                esc_next = 1'b0;
            else if (str_reg)
            begin
                if (text_byte == CH_BSLASH)
                    esc_next = 1'b1;
                else if (text_byte == CH_QUOTE)
                    str_next = 1'b0;
            end
            else if (text_byte == CH_QUOTE)
                str_next = 1'b1;
            else if (text_byte == CH_LBRACE)
            begin
                if (depth_reg != DEPTH_MAX)
                    depth_next = depth_reg + depth_t'(1);
            end
            else if (text_byte == CH_RBRACE)
            begin
                if (depth_reg <= depth_t'(1))
                begin
                    depth_next = '0;
                    closed     = 1'b1;
                end
                else
                    depth_next = depth_reg - depth_t'(1);
            end

            // limit in effect saturates at the counter's range
            passed = (cmp_t'(count_reg) < cmp_t'(limit)) && (count_reg != COUNT_MAX);
            if (passed)
                count_next = count_reg + count_t'(1);
            else
                drop_next = 1'b1;

            if (closed || end_of_text)
            begin
                step_out.has_result        = 1'b1;
                step_out.result.data_byte  = passed ? text_byte : 8'h00;
                step_out.result.byte_valid = passed;
                step_out.result.object_end = 1'b1;
                step_out.result.truncated  = drop_reg | ~passed;
                step_out.result.incomplete = ~closed;
                mode_next  = MODE_BETWEEN;
                str_next   = 1'b0;
                esc_next   = 1'b0;
                depth_next = '0;
                count_next = '0;
                drop_next  = 1'b0;
            end
            else if (passed)
            begin
                step_out.has_result        = 1'b1;
                step_out.result.data_byte  = text_byte;
                step_out.result.byte_valid = 1'b1;
            end
        end
    end

endmodule

/* hdl/json_array_object_splitter.sv */
// Top level of the JSON array object splitter
// Takes one byte of a JSON array text per transaction and sends out the bytes of each
// top-level object, marking object ends (with truncated and incomplete flags) and the
// end of the array. A byte is taken every cycle unless the output register holds a result
// that the receiver has not yet taken; each byte passes an input register, one pass of
// parse logic, and lands in the output register, where its result is offered. A byte that
// yields no result sends nothing. The per-object byte limit resets to 1023 and should be
// written only while no bytes are in flight.
module json_array_object_splitter
    import jaos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jaos_in_if.sink     text_in,
    jaos_out_if.source  obj_out,
    jaos_cfg_if.sink    cfg
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eot_reg;
    logic        out_valid_reg, out_valid_next;
    obj_result_t out_data_reg;
    limit_t      limit_reg;
    logic        advance;
    step_out_t   step_out;

    assign advance       = in_valid_reg && (!out_valid_reg || obj_out.ready);
    assign text_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg.valid)
            limit_reg <= cfg.object_byte_limit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text_in.ready)
            in_valid_reg <= text_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            in_byte_reg <= text_in.text_byte;
            in_eot_reg  <= text_in.end_of_text;
        end
    end

    jaos_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .limit       (limit_reg),
        .step_out    (step_out)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && step_out.has_result)
            out_valid_next = 1'b1;
        else if (obj_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load a new result only when one is produced
    always_ff @(posedge clk)
    begin
        if (advance && step_out.has_result)
            out_data_reg <= step_out.result;
    end

    assign obj_out.valid      = out_valid_reg;
    assign obj_out.data_byte  = out_data_reg.data_byte;
    assign obj_out.byte_valid = out_data_reg.byte_valid;
    assign obj_out.object_end = out_data_reg.object_end;
    assign obj_out.truncated  = out_data_reg.truncated;
    assign obj_out.incomplete = out_data_reg.incomplete;
    assign obj_out.array_end  = out_data_reg.array_end;

endmodule

/* hdl/jaos_checker.sv */
// Port-level checks for the JSON array object splitter, bound to the top level
`include "assert_macros.svh"

module jaos_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       object_end,
    input logic       truncated,
    input logic       incomplete,
    input logic       array_end
);

    // hold a stalled result until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // status flags only ride on an object end
    `ASSERT_IMPLY(a_flags_on_end, clk, rst_n, out_valid && (truncated || incomplete), object_end)

    // an array end carries nothing else
    `ASSERT_IMPLY(a_array_end_alone, clk, rst_n, out_valid && array_end,
                  !byte_valid && !object_end && data_byte == 8'h00)

    // an empty result is either an end mark or a dropped closing byte
    `ASSERT_IMPLY(a_empty_is_end, clk, rst_n, out_valid && !byte_valid,
                  data_byte == 8'h00 && (object_end || array_end))

endmodule

bind json_array_object_splitter jaos_checker u_jaos_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (obj_out.valid),
    .out_ready  (obj_out.ready),
    .data_byte  (obj_out.data_byte),
    .byte_valid (obj_out.byte_valid),
    .object_end (obj_out.object_end),
    .truncated  (obj_out.truncated),
    .incomplete (obj_out.incomplete),
    .array_end  (obj_out.array_end)
);

/* tb/sv/jaos_object_checker.sv */
// Checker for the JSON array object splitter: predicts each object result and compares it
`timescale 1ns / 1ps

module jaos_object_checker
    import jaos_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jaos_in_if   text_mon,
    jaos_out_if  out_mon,
    jaos_cfg_if  cfg_mon,
    output int   error_count,
    output int   results_due
);

    // Predicted parser state
    mode_t  split_mode    = MODE_BETWEEN;
    logic   str_open      = 1'b0;
    logic   escape_next   = 1'b0;
    logic   any_dropped   = 1'b0;
    depth_t nest_depth    = '0;
    count_t bytes_sent    = '0;
    limit_t byte_limit    = LIMIT_RESET;

    obj_result_t object_results_due[$];

    function automatic void clear_object_state();
        str_open    = 1'b0;
        escape_next = 1'b0;
        any_dropped = 1'b0;
        nest_depth  = '0;
        bytes_sent  = '0;
    endfunction

    // Advance the predicted parser by one text byte; return 1 when a result is due
    function automatic bit parse_text_byte(input logic [7:0] c, input logic eot,
                                           output obj_result_t res);
        logic closed;
        logic passed;
        cmp_t eff_limit;
        res    = '0;
        closed = 1'b0;
        if (split_mode == MODE_DONE)
        begin
            if (eot)
            begin
                split_mode = MODE_BETWEEN;
                clear_object_state();
            end
            return 1'b0;
        end
        if (split_mode != MODE_OBJECT)
        begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                c == CH_LBRACK || c == CH_COMMA)
            begin
                if (eot)
                begin
                    split_mode = MODE_BETWEEN;
                    clear_object_state();
                end
                return 1'b0;
            end
            if (c != CH_LBRACE)
            begin
                res.array_end = 1'b1;
                split_mode = eot ? MODE_BETWEEN : MODE_DONE;
                clear_object_state();
                return 1'b1;
            end
            split_mode = MODE_OBJECT;
            clear_object_state();
        end

        eff_limit = cmp_t'(byte_limit);
        if (eff_limit > cmp_t'(count_t'('1)))
            eff_limit = cmp_t'(count_t'('1));

        if (escape_next)
            escape_next = 1'b0;
        else if (str_open)
        begin
            if (c == CH_BSLASH)
                escape_next = 1'b1;
            else if (c == CH_QUOTE)
                str_open = 1'b0;
        end
        else if (c == CH_QUOTE)
            str_open = 1'b1;
        else if (c == CH_LBRACE)
        begin
            if (nest_depth != depth_t'('1))
                nest_depth = nest_depth + depth_t'(1);
        end
        else if (c == CH_RBRACE)
        begin
            if (nest_depth <= depth_t'(1))
            begin
                nest_depth = '0;
                closed = 1'b1;
            end
            else
                nest_depth = nest_depth - depth_t'(1);
        end

        if (cmp_t'(bytes_sent) < eff_limit)
        begin
            bytes_sent = bytes_sent + count_t'(1);
            passed = 1'b1;
        end
        else
        begin
            any_dropped = 1'b1;
            passed = 1'b0;
        end

        if (closed || eot)
        begin
            res.data_byte  = passed ? c : 8'h00;
            res.byte_valid = passed;
            res.object_end = 1'b1;
            res.truncated  = any_dropped;
            res.incomplete = !closed;
            split_mode = MODE_BETWEEN;
            clear_object_state();
            return 1'b1;
        end
        if (passed)
        begin
            res.data_byte  = c;
            res.byte_valid = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        obj_result_t pred;
        obj_result_t seen;
        if (!rst_n)
        begin
            split_mode = MODE_BETWEEN;
            clear_object_state();
            byte_limit = LIMIT_RESET;
            object_results_due.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
                byte_limit = cfg_mon.object_byte_limit;
            if (text_mon.valid && text_mon.ready)
            begin
                if (parse_text_byte(text_mon.text_byte, text_mon.end_of_text, pred))
                    object_results_due.push_back(pred);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                seen.data_byte  = out_mon.data_byte;
                seen.byte_valid = out_mon.byte_valid;
                seen.object_end = out_mon.object_end;
                seen.truncated  = out_mon.truncated;
                seen.incomplete = out_mon.incomplete;
                seen.array_end  = out_mon.array_end;
                if (object_results_due.size() == 0)
                begin
                    $error("unexpected result transaction: data_byte 0x%0h flags %b",
                           seen.data_byte, seen[4:0]);
                    error_count++;
                end
                else
                begin
                    pred = object_results_due.pop_front();
                    check_field("data_byte", pred.data_byte, seen.data_byte);
                    check_field("byte_valid", 8'(pred.byte_valid), 8'(seen.byte_valid));
                    check_field("object_end", 8'(pred.object_end), 8'(seen.object_end));
                    check_field("truncated", 8'(pred.truncated), 8'(seen.truncated));
                    check_field("incomplete", 8'(pred.incomplete), 8'(seen.incomplete));
                    check_field("array_end", 8'(pred.array_end), 8'(seen.array_end));
                end
            end
        end
        results_due <= object_results_due.size();
    end

endmodule

/* tb/sv/json_array_object_splitter_tb.sv */
// Testbench top for the JSON array object splitter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module json_array_object_splitter_tb;
    import jaos_pkg::*;

    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam int         HOLD_CYCLES = 200;
    localparam int         PHASE_ITEMS = 30;
    localparam int         N_PHASES    = 10;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    bit   sink_hold;
    event hold_go;
    int   error_count;
    int   results_due;

    logic [7:0] text_bytes[$];

    jaos_in_if  text_in();
    jaos_out_if obj_out();
    jaos_cfg_if cfg();

    json_array_object_splitter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .obj_out (obj_out),
        .cfg     (cfg)
    );

    jaos_object_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_mon    (text_in),
        .out_mon     (obj_out),
        .cfg_mon     (cfg),
        .error_count (error_count),
        .results_due (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("json_array_object_splitter regression: fail");
        $finish;
    end

    // Receiver: random stalls, none while calm, and never ready during a hold-off
    initial
    begin
        obj_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            obj_out.ready <= !sink_hold && (calm || $urandom_range(99) >= 13);
        end
    end

    initial
    begin
        sink_hold <= 1'b0;
        forever
        begin
            @(hold_go);
            sink_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic eot);
        if (!calm)
            while ($urandom_range(99) < 13)
            begin
                text_in.valid <= 1'b0;
                @(posedge clk);
            end
        text_in.valid       <= 1'b1;
        text_in.text_byte   <= c;
        text_in.end_of_text <= eot;
        @(posedge clk);
        while (!text_in.ready) @(posedge clk);
    endtask

    task automatic write_limit(input limit_t value);
        cfg.valid             <= 1'b1;
        cfg.object_byte_limit <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Hold the input until every predicted result is out, then let the pipe empty
    task automatic drain();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void push_junk();
        text_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void push_blank();
        repeat ($urandom_range(2))
            case ($urandom_range(3))
                0: text_bytes.push_back(CH_SPACE);
                1: text_bytes.push_back(CH_TAB);
                2: text_bytes.push_back(CH_LF);
                default: text_bytes.push_back(CH_CR);
            endcase
    endfunction

    function automatic void push_string();
        logic [7:0] b;
        text_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(6))
        begin
            b = 8'($urandom_range(255));
            if ($urandom_range(3) == 0)
                b = $urandom_range(1) ? CH_LBRACE : CH_RBRACE;
            if (b == CH_QUOTE || b == CH_BSLASH)
                text_bytes.push_back(CH_BSLASH);
            text_bytes.push_back(b);
        end
        text_bytes.push_back(CH_QUOTE);
    endfunction

    function automatic void push_object();
        int nest;
        text_bytes.push_back(CH_LBRACE);
        repeat ($urandom_range(3))
        begin
            push_blank();
            push_string();
            text_bytes.push_back(CH_COLON);
            case ($urandom_range(3))
                0: push_string();
                1:
                begin
                    nest = $urandom_range(1, 3);
                    repeat (nest) text_bytes.push_back(CH_LBRACE);
                    push_string();
                    text_bytes.push_back(CH_COLON);
                    push_string();
                    repeat (nest) text_bytes.push_back(CH_RBRACE);
                end
                2: repeat ($urandom_range(1, 4))
                    text_bytes.push_back(CH_DIGIT0 + 8'($urandom_range(9)));
                default: repeat ($urandom_range(1, 3)) push_junk();
            endcase
            text_bytes.push_back(CH_COMMA);
        end
        push_blank();
        text_bytes.push_back(CH_RBRACE);
    endfunction

    // Mostly well-formed arrays; some bare objects and noise; some cut short
    function automatic void build_text();
        int kind;
        int cut;
        text_bytes.delete();
        kind = $urandom_range(9);
        if (kind < 7)
        begin
            if ($urandom_range(4) != 0)
                text_bytes.push_back(CH_LBRACK);
            push_blank();
            repeat ($urandom_range(1, 4))
            begin
                push_object();
                push_blank();
                text_bytes.push_back(CH_COMMA);
                push_blank();
            end
            if ($urandom_range(3) != 0)
            begin
                text_bytes.push_back(CH_RBRACK);
                repeat ($urandom_range(3)) push_junk();
            end
        end
        else if (kind < 9)
            push_object();
        else
            repeat ($urandom_range(1, 8)) push_junk();
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > cut) text_bytes.pop_back();
        end
    endfunction

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    initial
    begin
        limit_t phase_limits[N_PHASES];
        int sent;
        phase_limits = '{16'd0, 16'd1, 16'd6, 16'd65535, 16'd20,
                         16'd3, 16'd1023, 16'd12, 16'd0, 16'd65535};
        text_in.valid         <= 1'b0;
        text_in.text_byte     <= 8'h00;
        text_in.end_of_text   <= 1'b0;
        cfg.valid             <= 1'b0;
        cfg.object_byte_limit <= '0;
        calm                  <= 1'b0;
        rst_n                 <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Separators, braces and an escaped quote inside a string, then the array end
        send_byte(CH_LBRACK, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_COMMA, 1'b0);
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_RBRACE, 1'b0);
        send_byte(CH_RBRACK, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Zero byte between objects, then a separator that ends the text
        send_byte(8'h00, 1'b1);
        send_byte(CH_COMMA, 1'b1);
        // Text ends on a pending escape
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b1);
        // Closing brace that also ends the text
        send_byte(CH_LBRACE, 1'b0);
        send_byte(CH_RBRACE, 1'b1);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            write_limit(phase_limits[p]);
            calm <= (p == 3 || p == 4 || p == 6);
            // Keep offering bytes while the receiver holds off, so the block backs up
            if (p == 4)
                -> hold_go;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                build_text();
                send_text();
                sent += text_bytes.size();
            end
        end

        // Nest past the depth ceiling; the early close leaves one stray brace
        text_bytes.delete();
        repeat (256) text_bytes.push_back(CH_LBRACE);
        repeat (256) text_bytes.push_back(CH_RBRACE);
        send_text();

        drain();
        if (error_count == 0)
            $display("json_array_object_splitter regression: pass");
        else
            $display("json_array_object_splitter regression: fail");
        $finish;
    end

endmodule

/* json_array_object_splitter.f */
+incdir+hdl
hdl/jaos_pkg.sv
hdl/jaos_ifs.sv
hdl/jaos_core.sv
hdl/json_array_object_splitter.sv
hdl/jaos_checker.sv
tb/sv/jaos_object_checker.sv
tb/sv/json_array_object_splitter_tb.sv
